// File: rtl/deadline_timer_queue_assert.svh
// Assertion macros shared by the deadline timer queue RTL.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/dtq_pkg.sv
// Types and constants of the deadline timer queue.
// Used by dtq_cell and deadline_timer_queue; depends on nothing.
package dtq_pkg;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 48;
    localparam int TMO_W  = 32;
    localparam int TAG_W  = 16;
    localparam int WAIT_W = 31;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_BAD_HANDLE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_EXPIRE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RESOLVE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [TIME_W-1:0]   now_ms;
        logic [TMO_W-1:0]    timeout_ms;
        logic [TAG_W-1:0]    request_tag;
        logic                has_handler;
        logic [SLOT_W-1:0]   handle;
    } t_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic [TAG_W-1:0]    fired_tag;
        logic [WAIT_W-1:0]   wait_ms;
        logic                none_pending;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   deadline;
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    tag;
        logic                report;
    } t_cand;

    typedef struct packed {
        t_op                 op;
        logic [TIME_W-1:0]   now;
        logic [SLOT_W-1:0]   handle;
        logic                wr_en;
        logic                kill_en;
        logic [SLOT_W-1:0]   target;
        logic [TIME_W-1:0]   wr_deadline;
        logic [TAG_W-1:0]    wr_tag;
        logic                wr_report;
    } t_cell_ctl;

endpackage

// File: rtl/dtq_cell.sv
// One timer slot of the queue and its stage of the candidate chain.
// Depends on dtq_pkg.
module dtq_cell import dtq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_slot,
    input  t_cell_ctl         i_ctl,
    input  t_cand             i_cand,
    output t_cand             o_cand
);

    logic              r_live;
    logic [TIME_W-1:0] r_deadline;
    logic [TAG_W-1:0]  r_tag;
    logic              r_report;
    t_cand             r_cand;
    t_cand             n_cand;
    t_cand             w_own;
    logic              w_qual;
    logic              w_take;
    logic              w_hit;

    assign w_hit = (i_ctl.target == i_slot);

    always_comb begin
        w_own.valid    = 1'b1;
        w_own.deadline = r_deadline;
        w_own.slot     = i_slot;
        w_own.tag      = r_tag;
        w_own.report   = r_report;
        case (i_ctl.op)
            OP_ADD:    w_qual = !r_live;
            OP_CANCEL: w_qual = r_live && (i_slot == i_ctl.handle);
            OP_QUERY:  w_qual = r_live;
            OP_EXPIRE: w_qual = r_live && (r_deadline <= i_ctl.now);
            default:   w_qual = 1'b0;
        endcase
        if (i_ctl.op inside {OP_QUERY, OP_EXPIRE}) begin
            w_take = w_qual && (!i_cand.valid || (r_deadline < i_cand.deadline));
        end else begin
            w_take = w_qual && !i_cand.valid;
        end
        n_cand = w_take ? w_own : i_cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= n_cand.valid;
            if (i_ctl.wr_en && w_hit) begin
                r_live <= 1'b1;
            end else if (i_ctl.kill_en && w_hit) begin
                r_live <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand.deadline <= n_cand.deadline;
        r_cand.slot     <= n_cand.slot;
        r_cand.tag      <= n_cand.tag;
        r_cand.report   <= n_cand.report;
        if (i_ctl.wr_en && w_hit) begin
            r_deadline <= i_ctl.wr_deadline;
            r_tag      <= i_ctl.wr_tag;
            r_report   <= i_ctl.wr_report;
        end
    end

    assign o_cand = r_cand;

endmodule

// File: rtl/deadline_timer_queue.sv
// Deadline timer queue: a pool of timers ordered by absolute deadline.
// Usage: drive i_item and raise start; the transaction is accepted at an edge
// where start is high and busy is low. Each result appears on o_result for one
// cycle with o_strobe high; the receiver cannot stall it. o_result.last marks
// the final result of a transaction.
// Every operation sweeps a candidate down a chain of QUEUE_DEPTH cells, one cell
// per cycle, then resolves it in S_RESOLVE. Add, cancel and query raise the
// result strobe as the machine leaves S_RESOLVE, and busy drops in the strobe
// cycle, so a new transaction may be accepted at the edge that ends the strobe.
// Expire repeats the sweep once per due timer plus once more; its final strobe
// follows the resolve of the last sweep, which finds no due timer.
// Reset (synchronous, active low) empties every slot and returns to idle;
// no clearing pass is needed.
// Depends on dtq_pkg, dtq_cell and deadline_timer_queue_assert.svh.
`include "deadline_timer_queue_assert.svh"

module deadline_timer_queue import dtq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CNT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_strobe, n_strobe;
    t_result            r_result, n_result;
    logic               r_pend_valid, n_pend_valid;
    logic [TAG_W-1:0]   r_pend_tag, n_pend_tag;

    t_op                r_op;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_dl;
    logic [TAG_W-1:0]   r_tag;
    logic               r_report;
    logic [SLOT_W-1:0]  r_handle;

    logic [TIME_W:0]    w_sum;
    logic [TIME_W:0]    w_diff;
    logic               w_accept;
    logic               w_wr_en;
    logic               w_kill_en;
    t_cell_ctl          w_ctl;
    t_cand              w_chain [0:QUEUE_DEPTH];
    t_cand              w_best;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_sum    = {1'b0, i_item.now_ms} + {{(TIME_W + 1 - TMO_W){1'b0}}, i_item.timeout_ms};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_item.op;
            r_now    <= i_item.now_ms;
            r_dl     <= w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
            r_tag    <= i_item.request_tag;
            r_report <= i_item.has_handler;
            r_handle <= i_item.handle;
        end
    end

    assign w_chain[0] = '0;
    assign w_best     = w_chain[QUEUE_DEPTH];

    always_comb begin
        w_ctl.op          = r_op;
        w_ctl.now         = r_now;
        w_ctl.handle      = r_handle;
        w_ctl.wr_en       = w_wr_en;
        w_ctl.kill_en     = w_kill_en;
        w_ctl.target      = w_best.slot;
        w_ctl.wr_deadline = r_dl;
        w_ctl.wr_tag      = r_tag;
        w_ctl.wr_report   = r_report;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dtq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (SLOT_W'(g)),
            .i_ctl   (w_ctl),
            .i_cand  (w_chain[g]),
            .o_cand  (w_chain[g+1])
        );
    end

    assign w_diff = {1'b0, w_best.deadline} - {1'b0, r_now};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_strobe     = 1'b0;
        n_result     = r_result;
        n_pend_valid = r_pend_valid;
        n_pend_tag   = r_pend_tag;
        w_wr_en      = 1'b0;
        w_kill_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state      = S_SWEEP;
                    n_count      = '0;
                    n_pend_valid = 1'b0;
                end
            end
            S_SWEEP: begin
                n_count = r_count + 1'b1;
                if (r_count == CNT_W'(QUEUE_DEPTH - 1)) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_result      = '0;
                n_result.last = 1'b1;
                n_state       = S_IDLE;
                n_strobe      = 1'b1;
                case (r_op)
                    OP_ADD: begin
                        if (w_best.valid) begin
                            w_wr_en       = 1'b1;
                            n_result.slot = w_best.slot;
                        end else begin
                            n_result.status = STATUS_FULL;
                        end
                    end
                    OP_CANCEL: begin
                        if (w_best.valid) begin
                            w_kill_en = 1'b1;
                        end else begin
                            n_result.status = STATUS_BAD_HANDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (!w_best.valid) begin
                            n_result.none_pending = 1'b1;
                        end else if (w_best.deadline <= r_now) begin
                            n_result.wait_ms = '0;
                        end else if (|w_diff[TIME_W:WAIT_W]) begin
                            n_result.wait_ms = WAIT_MAX;
                        end else begin
                            n_result.wait_ms = w_diff[WAIT_W-1:0];
                        end
                    end
                    OP_EXPIRE: begin
                        if (w_best.valid) begin
                            w_kill_en = 1'b1;
                            n_state   = S_SWEEP;
                            n_count   = '0;
                            n_strobe  = 1'b0;
                            if (w_best.report) begin
                                n_pend_valid = 1'b1;
                                n_pend_tag   = w_best.tag;
                                if (r_pend_valid) begin
                                    n_strobe           = 1'b1;
                                    n_result.fired     = 1'b1;
                                    n_result.fired_tag = r_pend_tag;
                                    n_result.last      = 1'b0;
                                end
                            end
                        end else if (r_pend_valid) begin
                            n_result.fired     = 1'b1;
                            n_result.fired_tag = r_pend_tag;
                        end
                    end
                    default: begin
                        n_result.status = STATUS_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_strobe     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_strobe     <= n_strobe;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_pend_tag <= n_pend_tag;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `DTQ_ASSERT_IMPL(a_strobe_after_resolve, i_clk, i_rst_n, r_strobe, $past(r_state == S_RESOLVE))
    `DTQ_ASSERT_NEXT(a_resolve_single_cycle, i_clk, i_rst_n, r_state == S_RESOLVE, r_state != S_RESOLVE)
    `DTQ_ASSERT_IMPL(a_fired_is_clean, i_clk, i_rst_n, r_strobe && r_result.fired, (r_result.status == STATUS_OK) && (r_result.wait_ms == '0) && !r_result.none_pending)
    `DTQ_ASSERT_IMPL(a_idle_no_pending, i_clk, i_rst_n, (r_state == S_IDLE) && $past(r_state == S_RESOLVE), r_strobe && r_result.last)

endmodule
